/* sv/gcom_pkg.sv */
// package for the gc object index mark filter
// holds field widths, table constants and request/status codes; no dependencies
`default_nettype none
package gcom_pkg;
  localparam int unsigned Capacity   = 256;
  localparam int unsigned SlotW      = $clog2(Capacity);
  localparam int unsigned CountW     = $clog2(Capacity) + 1;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned SizeW      = 29;
  localparam int unsigned TypeW      = 8;
  localparam int unsigned MaxEntries = (Capacity - 1) / 2;
  localparam logic [63:0] MixMult    = 64'hff51afd7ed558ccd;
  localparam int unsigned MixShift   = 33;
  localparam int unsigned InDataW    = 104;
  localparam int unsigned OutDataW   = 104;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;
endpackage
`default_nettype wire

/* sv/gc_object_index_mark_filter.sv */
// top level of the gc object index mark filter: hashed object table with range lookup
// depends on gcom_pkg; the slot payload sits in one synchronous memory, marks/used in flops
//
// One transfer in, one transfer out, one item worked on at a time. The hash is computed in steps
// (32-bit multiply partial products, then add and fold). An insert then probes slot by slot
// until it finds a free one. A mark reads, then compares, each occupied slot of its probe path
// and stops at the free slot that ends it. On a miss it scans all Capacity slots, reading and
// comparing each occupied slot and stepping over each free one, and then finishes. A hit passes
// through S_HIT, and every result through S_OUT to load the output register. Clear, empty, a
// full table and an ignored word go straight from S_MUL to S_OUT, since marks and used bits
// live in flip-flops. The read-compare loop over occupied slots sets the rate. A finished
// result waits in the output register, so the next transfer is taken while it is held.
`default_nettype none
module gc_object_index_mark_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // address, object_size, object_type, zero pad
  input  wire logic [gcom_pkg::InDataW-1:0]  s_axis_tdata,
  // kind
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // newly_marked, found_base, found_size, found_type, zero pad
  output logic [gcom_pkg::OutDataW-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                         m_axis_tuser
);
  import gcom_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_HASH, S_PROBE, S_SCAN, S_HIT, S_OUT
  } state_e;

  localparam int unsigned MemW = AddrW + SizeW + TypeW;

  state_e               state_q;
  kind_e                kind_q;
  logic [AddrW-1:0]     addr_q;
  logic [SizeW-1:0]     size_q;
  logic [TypeW-1:0]     type_q;
  logic [63:0]          v_q;
  logic [63:0]          plo_q;
  logic [31:0]          phi_q;
  logic [SlotW-1:0]     pos_q;
  logic [CountW-1:0]    cnt_q;
  logic [CountW-1:0]    scan_q;
  logic                 rd_pend_q;
  logic [Capacity-1:0]  used_q, mark_q;
  logic [MemW-1:0]      mem [Capacity];
  logic [MemW-1:0]      rdata_q;
  logic [SlotW-1:0]     rpos_q;
  logic [1:0]           wstat_q;
  logic                 wfresh_q;
  logic [MemW-1:0]      wfound_q;
  logic                 ovalid_q;
  logic [1:0]           ostat_q;
  logic                 ofresh_q;
  logic [MemW-1:0]      ofound_q;

  logic [63:0] mixed, hsum;
  logic [AddrW-1:0] rbase;
  logic [SizeW-1:0] rsize;
  logic [AddrW-1:0] rdiff;
  logic [SlotW-1:0] rd_addr;
  logic             rd_en, wr_en;
  logic             out_load;

  assign hsum     = plo_q + {phi_q, 32'd0};
  assign mixed    = hsum ^ (hsum >> MixShift);
  assign rbase    = rdata_q[MemW-1 -: AddrW];
  assign rsize    = rdata_q[TypeW +: SizeW];
  assign rdiff    = addr_q - rbase;
  assign out_load = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_q;
    wr_en   = 1'b0;
    case (state_q)
      S_PROBE: begin
        if (kind_q == KIND_INSERT) begin
          wr_en = !used_q[pos_q];
        end else begin
          rd_en = used_q[pos_q] && !rd_pend_q;
        end
      end
      S_SCAN: begin
        rd_en   = !rd_pend_q && !scan_q[CountW-1];
        rd_addr = scan_q[SlotW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= {addr_q, size_q, type_q};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rpos_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      mark_q    <= '0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q   <= kind_e'(s_axis_tuser);
            addr_q   <= s_axis_tdata[AddrW-1:0];
            size_q   <= s_axis_tdata[AddrW +: SizeW];
            type_q   <= s_axis_tdata[AddrW+SizeW +: TypeW];
            v_q      <= s_axis_tdata[AddrW-1:0] ^ (s_axis_tdata[AddrW-1:0] >> MixShift);
            wstat_q  <= ST_DONE;
            wfresh_q <= 1'b0;
            wfound_q <= '0;
            state_q  <= S_MUL;
          end
        end
        S_MUL: begin
          plo_q <= {32'd0, v_q[31:0]} * {32'd0, MixMult[31:0]};
          phi_q <= v_q[31:0] * MixMult[63:32] + v_q[63:32] * MixMult[31:0];
          case (kind_q)
            KIND_INSERT: begin
              if (cnt_q >= CountW'(MaxEntries)) begin
                wstat_q <= ST_FULL;
                state_q <= S_OUT;
              end else begin
                state_q <= S_HASH;
              end
            end
            KIND_MARK: begin
              if (addr_q == '0 || addr_q[2:0] != 3'd0) begin
                wstat_q <= ST_IGNORED;
                state_q <= S_OUT;
              end else begin
                state_q <= S_HASH;
              end
            end
            KIND_CLEAR: begin
              mark_q  <= '0;
              state_q <= S_OUT;
            end
            default: begin
              mark_q  <= '0;
              used_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        S_HASH: begin
          pos_q   <= SlotW'(mixed % Capacity);
          state_q <= S_PROBE;
        end
        S_PROBE: begin
          if (kind_q == KIND_INSERT) begin
            if (used_q[pos_q]) begin
              pos_q <= SlotW'((CountW'(pos_q) + 1'b1) % Capacity);
            end else begin
              used_q[pos_q] <= 1'b1;
              mark_q[pos_q] <= 1'b0;
              cnt_q         <= cnt_q + 1'b1;
              state_q       <= S_OUT;
            end
          end else if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            if (rbase == addr_q) begin
              state_q <= S_HIT;
            end else begin
              pos_q <= SlotW'((CountW'(pos_q) + 1'b1) % Capacity);
            end
          end else if (used_q[pos_q]) begin
            rd_pend_q <= 1'b1;
          end else begin
            scan_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            if (addr_q >= rbase && rdiff < AddrW'(rsize)) begin
              state_q <= S_HIT;
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end else if (scan_q[CountW-1]) begin
            wstat_q <= ST_MISS;
            state_q <= S_OUT;
          end else if (used_q[scan_q[SlotW-1:0]]) begin
            rd_pend_q <= 1'b1;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_HIT: begin
          wfound_q        <= rdata_q;
          wfresh_q        <= !mark_q[rpos_q];
          mark_q[rpos_q]  <= 1'b1;
          state_q         <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            ostat_q  <= wstat_q;
            ofresh_q <= wfresh_q;
            ofound_q <= wfound_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {2'd0, ofound_q[TypeW-1:0], ofound_q[TypeW +: SizeW],
                          ofound_q[MemW-1 -: AddrW], ofresh_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxEntries)) else $error("entry count overflow");
  a_fresh_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && ofresh_q |-> ostat_q == ST_DONE) else $error("fresh mark without hit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && $stable(ostat_q)) else $error("result lost");
endmodule
`default_nettype wire
